FILE: src/rgb_to_hsl_pixel_macros.svh
// Assertion macros used by the rgb_to_hsl_pixel checker.
`ifndef RGB_TO_HSL_PIXEL_MACROS_SVH
`define RGB_TO_HSL_PIXEL_MACROS_SVH

// same-cycle implication, disabled during reset
`define RHP_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RHP_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rhp_pkg.sv
// Types and constants for the RGB to HSL pixel converter.
package rhp_pkg;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	localparam int QW     = 8;   // quotient bits, one per divider stage
	localparam int HREM_W = 20;  // hue dividend 510*n + 6*d
	localparam int HDIV_W = 12;  // hue divisor 12*d
	localparam int SREM_W = 17;  // saturation dividend 510*d + q
	localparam int SDIV_W = 9;   // saturation divisor 2*q

	typedef struct packed {
		logic [HREM_W-1:0] hrem;
		logic [HDIV_W-1:0] hdiv;
		logic [QW-1:0]     hq;
		logic [SREM_W-1:0] srem;
		logic [SDIV_W-1:0] sdiv;
		logic [QW-1:0]     sq;
		logic [7:0]        light;
		logic              chroma;
		logic              nul;
		logic              rend;
	} div_t;

endpackage

FILE: src/rgb_to_hsl_pixel.sv
// Throughput: one pixel per clock while the output is not stalled; max/min, sector numerator,
// dividend setup, then two 8-step restoring dividers (hue, saturation) sharing 8 stages.
// Each stage has its own valid bit and holds only while the stage after it is full.
// arst_n clears all valid bits; payload registers are not reset.
module rgb_to_hsl_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic [0:0]  s_axis_tuser,   // is_null[0]
	input  logic        s_axis_tlast,   // row_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // hue[7:0], lightness[15:8], saturation[23:16]
	output logic [0:0]  m_axis_tuser,   // null_out[0]
	output logic        m_axis_tlast    // row_end_out
);

	logic [7:0] in_r, in_g, in_b;
	logic [7:0] mx_c, mn_c;
	rhp_pkg::sector_t sec_c;

	assign in_r = s_axis_tdata[7:0];
	assign in_g = s_axis_tdata[15:8];
	assign in_b = s_axis_tdata[23:16];

	// stage 1: max, min, sector
	always_comb begin
		mx_c = in_r;
		if (in_g > mx_c) mx_c = in_g;
		if (in_b > mx_c) mx_c = in_b;
		mn_c = in_r;
		if (in_g < mn_c) mn_c = in_g;
		if (in_b < mn_c) mn_c = in_b;
		if (in_r == mx_c)
			sec_c = rhp_pkg::SEC_RED;
		else if (in_g == mx_c)
			sec_c = rhp_pkg::SEC_GREEN;
		else
			sec_c = rhp_pkg::SEC_BLUE;
	end

	logic             v_s1, rdy_s1;
	logic [7:0]       r_s1, g_s1, b_s1, mx_s1, mn_s1;
	rhp_pkg::sector_t sec_s1;
	logic             nul_s1, rend_s1;

	logic             v_s2, rdy_s2;
	logic [7:0]       d_s2, q_s2, light_s2;
	logic [10:0]      n_s2;
	logic             nul_s2, rend_s2;

	logic                pv_s [rhp_pkg::QW+1];  // index k is stage s(3+k)
	rhp_pkg::div_t       pipe_s [rhp_pkg::QW+1];
	logic                pr [rhp_pkg::QW+1];

	assign rdy_s1 = !v_s1 || rdy_s2;
	assign rdy_s2 = !v_s2 || pr[0];
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			r_s1    <= in_r;
			g_s1    <= in_g;
			b_s1    <= in_b;
			mx_s1   <= mx_c;
			mn_s1   <= mn_c;
			sec_s1  <= sec_c;
			nul_s1  <= s_axis_tuser[0];
			rend_s1 <= s_axis_tlast;
		end
	end

	// stage 2: d, q, sector numerator, lightness
	logic [7:0]  d_c;
	logic [8:0]  s_c, q_c;
	logic [10:0] d6_c, n_c;
	logic [7:0]  light_c;

	always_comb begin
		d_c     = mx_s1 - mn_s1;
		s_c     = {1'b0, mx_s1} + {1'b0, mn_s1};
		q_c     = (s_c <= 9'd255) ? s_c : 9'd510 - s_c;
		light_c = 8'((s_c + 9'd1) >> 1);
		d6_c    = (11'(d_c) << 2) + (11'(d_c) << 1);
		case (sec_s1)
			rhp_pkg::SEC_RED: begin
				if (g_s1 >= b_s1)
					n_c = 11'(g_s1) - 11'(b_s1);
				else
					n_c = d6_c + 11'(g_s1) - 11'(b_s1);
			end
			rhp_pkg::SEC_GREEN: begin
				n_c = (11'(d_c) << 1) + 11'(b_s1) - 11'(r_s1);
			end
			default: begin
				n_c = (11'(d_c) << 2) + 11'(r_s1) - 11'(g_s1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			d_s2     <= d_c;
			q_s2     <= q_c[7:0];
			n_s2     <= n_c;
			light_s2 <= light_c;
			nul_s2   <= nul_s1;
			rend_s2  <= rend_s1;
		end
	end

	// stage 3: dividends and divisors
	rhp_pkg::div_t init_c;

	always_comb begin
		init_c.hrem   = (rhp_pkg::HREM_W'(n_s2) << 9) - (rhp_pkg::HREM_W'(n_s2) << 1)
			+ (rhp_pkg::HREM_W'(d_s2) << 2) + (rhp_pkg::HREM_W'(d_s2) << 1);
		init_c.hdiv   = (rhp_pkg::HDIV_W'(d_s2) << 3) + (rhp_pkg::HDIV_W'(d_s2) << 2);
		init_c.hq     = '0;
		init_c.srem   = (rhp_pkg::SREM_W'(d_s2) << 9) - (rhp_pkg::SREM_W'(d_s2) << 1)
			+ rhp_pkg::SREM_W'(q_s2);
		init_c.sdiv   = {q_s2, 1'b0};
		init_c.sq     = '0;
		init_c.light  = nul_s2 ? 8'd0 : light_s2;
		init_c.chroma = !nul_s2 && (d_s2 != 8'd0);
		init_c.nul    = nul_s2;
		init_c.rend   = rend_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s[0] <= 1'b0;
		end else if (pr[0]) begin
			pv_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pr[0] && v_s2) begin
			pipe_s[0] <= init_c;
		end
	end

	// stages 4..11: one quotient bit of each divider per stage, MSB first
	for (genvar k = 0; k < rhp_pkg::QW; k++) begin : g_step
		localparam int B = rhp_pkg::QW - 1 - k;
		logic [rhp_pkg::HREM_W-1:0] hsh;
		logic [rhp_pkg::SREM_W-1:0] ssh;
		rhp_pkg::div_t              nxt;

		assign hsh = rhp_pkg::HREM_W'(pipe_s[k].hdiv) << B;
		assign ssh = rhp_pkg::SREM_W'(pipe_s[k].sdiv) << B;
		assign pr[k] = !pv_s[k] || pr[k+1];

		always_comb begin
			nxt = pipe_s[k];
			if (pipe_s[k].hrem >= hsh) begin
				nxt.hrem  = pipe_s[k].hrem - hsh;
				nxt.hq[B] = 1'b1;
			end
			if (pipe_s[k].srem >= ssh) begin
				nxt.srem  = pipe_s[k].srem - ssh;
				nxt.sq[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv_s[k+1] <= 1'b0;
			end else if (pr[k+1]) begin
				pv_s[k+1] <= pv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (pr[k+1] && pv_s[k]) begin
				pipe_s[k+1] <= nxt;
			end
		end
	end

	assign pr[rhp_pkg::QW] = !pv_s[rhp_pkg::QW] || m_axis_tready;

	assign m_axis_tvalid = pv_s[rhp_pkg::QW];
	assign m_axis_tdata  = {
		pipe_s[rhp_pkg::QW].chroma ? pipe_s[rhp_pkg::QW].sq : 8'd0,
		pipe_s[rhp_pkg::QW].light,
		pipe_s[rhp_pkg::QW].chroma ? pipe_s[rhp_pkg::QW].hq : 8'd0
	};
	assign m_axis_tuser  = pipe_s[rhp_pkg::QW].nul;
	assign m_axis_tlast  = pipe_s[rhp_pkg::QW].rend;

endmodule

FILE: src/rhp_checker.sv
// Port-level checker for rgb_to_hsl_pixel and its bind.
`include "rgb_to_hsl_pixel_macros.svh"

module rhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
	input logic [0:0]  s_axis_tuser,   // is_null[0]
	input logic        s_axis_tlast,   // row_end
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,   // hue[7:0], lightness[15:8], saturation[23:16]
	input logic [0:0]  m_axis_tuser,   // null_out[0]
	input logic        m_axis_tlast    // row_end_out
);

	logic [7:0] hue_w, light_w, sat_w;
	logic       in_seen;

	assign hue_w   = m_axis_tdata[7:0];
	assign light_w = m_axis_tdata[15:8];
	assign sat_w   = m_axis_tdata[23:16];
	assign in_seen = s_axis_tvalid && s_axis_tlast && (s_axis_tdata != 24'd0) && s_axis_tuser[0];

	`RHP_ASSERT_NXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast) && (in_seen || !in_seen), "output word changed while stalled")
	`RHP_ASSERT_IMP(a_null_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 24'd0, "null word carries nonzero data")
	`RHP_ASSERT_IMP(a_black, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0] && light_w == 8'd0, hue_w == 8'd0 && sat_w == 8'd0, "zero lightness with nonzero hue or saturation")
	`RHP_ASSERT_IMP(a_gray_hue, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0] && sat_w == 8'd0, hue_w == 8'd0, "zero saturation with nonzero hue")
	`RHP_ASSERT_IMP(a_drain_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready, "empty output stage but input not ready")

endmodule

bind rgb_to_hsl_pixel rhp_checker u_rhp_checker (.*);
